FILE: rtl/qxm_pkg.sv
// ----------------------------------------------------------------------------
// qxm_pkg
// Shared types and constants of the quad-X motor mixer with desaturation.
// ----------------------------------------------------------------------------
package qxm_pkg;

   localparam int CMD_FRAC   = 4;
   localparam int SCALE_FRAC = 16;
   localparam int WIDE_FRAC  = CMD_FRAC + SCALE_FRAC;

   localparam int PULSE_W    = 12;
   localparam int LIMIT_W    = 15;
   localparam int CMD_W      = 16;
   localparam int SIGN_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   localparam int SCALE_W = SCALE_FRAC + 1;
   localparam int RP_W    = CMD_W + 2;
   localparam int DEN_W   = CMD_W + 1;
   localparam int NUM_W   = PULSE_W + WIDE_FRAC;
   localparam int REM_W   = DEN_W + SCALE_FRAC + 1;
   localparam int BASE_W  = NUM_W + 2;
   localparam int DIV_LAT = SCALE_W + 1;

   localparam longint SAT_NUM = 9999;
   localparam longint SAT_DEN = 10000;
   localparam int SAT_THRESH =
      int'((SAT_NUM * (longint'(1) << SCALE_FRAC) + SAT_DEN - 1) / SAT_DEN);

   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PULSE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_PULSE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_LIMIT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_SIGNS   = 3'd6;

   localparam logic [PULSE_W-1:0] IDLE_RESET  = 12'd1000;
   localparam logic [PULSE_W-1:0] MAX_RESET   = 12'd2000;
   localparam logic [PULSE_W-1:0] STOP_RESET  = 12'd900;
   localparam logic [LIMIT_W-1:0] ROLL_RESET  = 15'd4000;
   localparam logic [LIMIT_W-1:0] PITCH_RESET = 15'd4000;
   localparam logic [LIMIT_W-1:0] YAW_RESET   = 15'd3200;
   localparam logic [SIGN_W-1:0]  SIGNS_RESET = 12'd0;

   typedef struct packed {
      logic [PULSE_W-1:0]      throttle;
      logic signed [CMD_W-1:0] roll_command;
      logic signed [CMD_W-1:0] pitch_command;
      logic signed [CMD_W-1:0] yaw_command;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic [PULSE_W-1:0]      motor_one;
      logic [PULSE_W-1:0]      motor_two;
      logic [PULSE_W-1:0]      motor_three;
      logic [PULSE_W-1:0]      motor_four;
      logic [SCALE_W-1:0]      tilt_scale;
      logic [SCALE_W-1:0]      twist_scale;
      logic signed [CMD_W-1:0] applied_yaw;
      logic                    saturated;
   } rsp_type;

endpackage

FILE: rtl/qxm_divider.sv
// ----------------------------------------------------------------------------
// qxm_divider
// Pipelined restoring divider, one quotient bit per stage, quotient limited
// to one in Q1.16 scale format.
// ----------------------------------------------------------------------------
module qxm_divider (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [qxm_pkg::NUM_W-1:0]          num_in,
   input  logic [qxm_pkg::DEN_W-1:0]          den_in,
   output logic [qxm_pkg::SCALE_W-1:0]        quot_out
);

   localparam int SW = qxm_pkg::SCALE_W;
   localparam int RW = qxm_pkg::REM_W;
   localparam int DW = qxm_pkg::DEN_W;

   logic [RW-1:0] rem_ff  [SW];
   logic [DW-1:0] den_ff  [SW];
   logic [SW-1:0] quot_ff [SW+1];

   logic [RW-1:0] cap;
   logic [RW-1:0] num_x;
   logic [RW-1:0] rem_in;

   // limit numerator so the quotient never exceeds one
   assign cap    = RW'(den_in) << qxm_pkg::SCALE_FRAC;
   assign num_x  = RW'(num_in);
   assign rem_in = (num_x >= cap) ? cap : num_x;

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= rem_in;
         den_ff[0]  <= den_in;
         quot_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < SW; j++) begin : g_step
      localparam int SH = qxm_pkg::SCALE_FRAC - j;
      logic [RW-1:0] sub;
      logic          go;
      assign sub = RW'(den_ff[j]) << SH;
      assign go  = rem_ff[j] >= sub;
      always_ff @(posedge clock) begin
         if (enable) begin
            quot_ff[j+1] <= quot_ff[j] | (SW'(go) << SH);
         end
      end
      if (j < SW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[j+1] <= go ? (rem_ff[j] - sub) : rem_ff[j];
               den_ff[j+1] <= den_ff[j];
            end
         end
      end
   end

   assign quot_out = quot_ff[SW];

endmodule

FILE: rtl/quad_x_motor_mixer_desaturate_unit.sv
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_desaturate_unit
// Quad-X motor mixer: throttle check, axis clamps, roll/pitch and yaw
// desaturation scales, rounded motor pulse widths.
// ----------------------------------------------------------------------------
// Fully pipelined: one command beat is taken every cycle unless the result
// side stalls; new beats enter while older ones are in flight. Most of the
// depth is in the two scale divisions (roll/pitch, then yaw), each a restoring
// divider per motor that resolves one quotient bit per stage. A result-side
// stall holds the whole pipe. The user must write registers via csr_* with
// index in register order, only while no beat is in flight; unenforced.
module quad_x_motor_mixer_desaturate_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  qxm_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output qxm_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [qxm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [qxm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int PW   = qxm_pkg::PULSE_W;
   localparam int CW   = qxm_pkg::CMD_W;
   localparam int LW   = qxm_pkg::LIMIT_W;
   localparam int RPW  = qxm_pkg::RP_W;
   localparam int DW   = qxm_pkg::DEN_W;
   localparam int NW   = qxm_pkg::NUM_W;
   localparam int SW   = qxm_pkg::SCALE_W;
   localparam int BW   = qxm_pkg::BASE_W;
   localparam int WF   = qxm_pkg::WIDE_FRAC;
   localparam int SF   = qxm_pkg::SCALE_FRAC;
   localparam int LAT  = qxm_pkg::DIV_LAT;
   localparam int VW   = BW + 2;
   localparam int MW   = CW + SW;
   localparam int VLD_N = 2 * LAT + 9;

   typedef struct packed {
      logic                    err;
      logic [PW-1:0]           thr;
      logic [3:0][RPW-1:0]     rp;
      logic signed [CW-1:0]    yaw;
      logic                    yclamp;
      logic [3:0]              zero;
   } ctx1_type;

   typedef struct packed {
      logic                    err;
      logic [3:0][BW-1:0]      base;
      logic signed [CW-1:0]    yaw;
      logic                    yclamp;
      logic [SW-1:0]           scale1;
      logic [3:0]              zero;
   } ctx2_type;

   typedef struct packed {
      logic                    err;
      logic                    yneg;
      logic                    yclamp;
      logic [SW-1:0]           scale1;
      logic [SW-1:0]           scale2;
   } ctx3_type;

   // configuration
   logic [PW-1:0]               idle_ff, max_ff, stop_ff;
   logic [LW-1:0]               roll_lim_ff, pitch_lim_ff, yaw_lim_ff;
   logic [qxm_pkg::SIGN_W-1:0]  signs_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff      <= qxm_pkg::IDLE_RESET;
         max_ff       <= qxm_pkg::MAX_RESET;
         stop_ff      <= qxm_pkg::STOP_RESET;
         roll_lim_ff  <= qxm_pkg::ROLL_RESET;
         pitch_lim_ff <= qxm_pkg::PITCH_RESET;
         yaw_lim_ff   <= qxm_pkg::YAW_RESET;
         signs_ff     <= qxm_pkg::SIGNS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            qxm_pkg::CSR_IDLE_PULSE:  idle_ff      <= csr_data[PW-1:0];
            qxm_pkg::CSR_MAX_PULSE:   max_ff       <= csr_data[PW-1:0];
            qxm_pkg::CSR_STOP_PULSE:  stop_ff      <= csr_data[PW-1:0];
            qxm_pkg::CSR_ROLL_LIMIT:  roll_lim_ff  <= csr_data[LW-1:0];
            qxm_pkg::CSR_PITCH_LIMIT: pitch_lim_ff <= csr_data[LW-1:0];
            qxm_pkg::CSR_YAW_LIMIT:   yaw_lim_ff   <= csr_data[LW-1:0];
            qxm_pkg::CSR_MIX_SIGNS:   signs_ff     <= csr_data[qxm_pkg::SIGN_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic             adv;
   logic [VLD_N-1:0] vld_ff;

   assign adv       = !vld_ff[VLD_N-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[VLD_N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[VLD_N-2:0], req_valid};
      end
   end

   function automatic logic signed [CW-1:0] clamp_cmd(input logic signed [CW-1:0] v,
                                                      input logic [LW-1:0] lim);
      logic signed [CW:0] lp;
      logic signed [CW:0] nl;
      logic signed [CW:0] vx;
      logic signed [CW-1:0] r;
      lp = $signed({{(CW + 1 - LW){1'b0}}, lim});
      nl = -lp;
      vx = {v[CW-1], v};
      if (vx > lp) begin
         r = lp[CW-1:0];
      end else if (vx < nl) begin
         r = nl[CW-1:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

   // stage 1: throttle check and axis clamps
   logic                 s1_err_in, s1_yclamp_in;
   logic signed [CW-1:0] s1_roll_in, s1_pitch_in, s1_yaw_in;
   logic                 s1_err_ff, s1_yclamp_ff;
   logic [PW-1:0]        s1_thr_ff;
   logic signed [CW-1:0] s1_roll_ff, s1_pitch_ff, s1_yaw_ff;

   always_comb begin
      s1_err_in    = (req_data.throttle < idle_ff) || (req_data.throttle > max_ff);
      s1_roll_in   = clamp_cmd(req_data.roll_command, roll_lim_ff);
      s1_pitch_in  = clamp_cmd(req_data.pitch_command, pitch_lim_ff);
      s1_yaw_in    = clamp_cmd(req_data.yaw_command, yaw_lim_ff);
      s1_yclamp_in = s1_yaw_in != req_data.yaw_command;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_err_ff    <= s1_err_in;
         s1_thr_ff    <= req_data.throttle;
         s1_roll_ff   <= s1_roll_in;
         s1_pitch_ff  <= s1_pitch_in;
         s1_yaw_ff    <= s1_yaw_in;
         s1_yclamp_ff <= s1_yclamp_in;
      end
   end

   // stage 2: roll/pitch mix
   logic signed [RPW-1:0] s2_rp_in [4];
   logic signed [RPW-1:0] s2_rp_ff [4];
   logic                  s2_err_ff, s2_yclamp_ff;
   logic [PW-1:0]         s2_thr_ff;
   logic signed [CW-1:0]  s2_yaw_ff;

   always_comb begin
      logic signed [RPW-1:0] rx;
      logic signed [RPW-1:0] px;
      rx = {{2{s1_roll_ff[CW-1]}}, s1_roll_ff};
      px = {{2{s1_pitch_ff[CW-1]}}, s1_pitch_ff};
      for (int m = 0; m < 4; m++) begin
         s2_rp_in[m] = (signs_ff[3*m] ? -rx : rx) + (signs_ff[3*m+1] ? -px : px);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_rp_ff     <= s2_rp_in;
         s2_err_ff    <= s1_err_ff;
         s2_thr_ff    <= s1_thr_ff;
         s2_yaw_ff    <= s1_yaw_ff;
         s2_yclamp_ff <= s1_yclamp_ff;
      end
   end

   // stage 3: headroom and divisor for the roll/pitch scale
   logic [NW-1:0] s3_num_in [4];
   logic [DW-1:0] s3_den_in [4];
   ctx1_type      s3_ctx_in;
   logic [NW-1:0] s3_num_ff [4];
   logic [DW-1:0] s3_den_ff [4];
   ctx1_type      s3_ctx_ff;

   always_comb begin
      logic [PW-1:0]         up;
      logic [PW-1:0]         dn;
      logic signed [RPW-1:0] nrp;
      up = max_ff - s2_thr_ff;
      dn = s2_thr_ff - idle_ff;
      s3_ctx_in.err    = s2_err_ff;
      s3_ctx_in.thr    = s2_thr_ff;
      s3_ctx_in.yaw    = s2_yaw_ff;
      s3_ctx_in.yclamp = s2_yclamp_ff;
      for (int m = 0; m < 4; m++) begin
         nrp = -s2_rp_ff[m];
         s3_ctx_in.rp[m]   = s2_rp_ff[m];
         s3_ctx_in.zero[m] = s2_rp_ff[m] == '0;
         s3_den_in[m] = s2_rp_ff[m][RPW-1] ? nrp[DW-1:0] : s2_rp_ff[m][DW-1:0];
         s3_num_in[m] = s2_rp_ff[m][RPW-1] ? {dn, {WF{1'b0}}} : {up, {WF{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_num_ff <= s3_num_in;
         s3_den_ff <= s3_den_in;
         s3_ctx_ff <= s3_ctx_in;
      end
   end

   // roll/pitch scale division
   logic [SW-1:0] q1 [4];
   ctx1_type      c1_ff [LAT];

   for (genvar m = 0; m < 4; m++) begin : g_div1
      qxm_divider u_div (
         .clock    (clock),
         .enable   (adv),
         .num_in   (s3_num_ff[m]),
         .den_in   (s3_den_ff[m]),
         .quot_out (q1[m])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff[0] <= s3_ctx_ff;
         for (int i = 1; i < LAT; i++) begin
            c1_ff[i] <= c1_ff[i-1];
         end
      end
   end

   // stage 5: smallest roll/pitch candidate
   logic [SW-1:0] s5_scale_in;
   logic [SW-1:0] s5_scale_ff;
   ctx1_type      s5_ctx_ff;

   always_comb begin
      s5_scale_in = SW'(1) << SF;
      for (int m = 0; m < 4; m++) begin
         if (!c1_ff[LAT-1].zero[m] && (q1[m] < s5_scale_in)) begin
            s5_scale_in = q1[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_scale_ff <= s5_scale_in;
         s5_ctx_ff   <= c1_ff[LAT-1];
      end
   end

   // stage 6: motor base after roll/pitch
   ctx2_type s6_ctx_in;
   ctx2_type s6_ctx_ff;

   always_comb begin
      logic signed [BW-1:0]     thrx;
      logic signed [RPW+SW:0]   prod;
      logic signed [RPW+SW:0]   sum;
      thrx = $signed({{(BW - NW){1'b0}}, s5_ctx_ff.thr, {WF{1'b0}}});
      s6_ctx_in.err    = s5_ctx_ff.err;
      s6_ctx_in.yaw    = s5_ctx_ff.yaw;
      s6_ctx_in.yclamp = s5_ctx_ff.yclamp;
      s6_ctx_in.scale1 = s5_scale_ff;
      s6_ctx_in.zero   = '0;
      for (int m = 0; m < 4; m++) begin
         prod = $signed(s5_ctx_ff.rp[m]) * $signed({1'b0, s5_scale_ff});
         sum  = thrx + prod;
         s6_ctx_in.base[m] = sum[BW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_ctx_ff <= s6_ctx_in;
      end
   end

   // stage 7: headroom and divisor for the yaw scale
   logic [NW-1:0] s7_num_in [4];
   logic [DW-1:0] s7_den_in [4];
   ctx2_type      s7_ctx_in;
   logic [NW-1:0] s7_num_ff [4];
   logic [DW-1:0] s7_den_ff [4];
   ctx2_type      s7_ctx_ff;

   always_comb begin
      logic signed [BW:0]   lo;
      logic signed [BW:0]   hi;
      logic signed [BW:0]   b;
      logic signed [BW:0]   room;
      logic signed [CW:0]   yx;
      logic signed [CW:0]   ny;
      logic                 ypos;
      lo = $signed({{(BW + 1 - NW){1'b0}}, idle_ff, {WF{1'b0}}});
      hi = $signed({{(BW + 1 - NW){1'b0}}, max_ff, {WF{1'b0}}});
      yx = {s6_ctx_ff.yaw[CW-1], s6_ctx_ff.yaw};
      ny = -yx;
      s7_ctx_in = s6_ctx_ff;
      for (int m = 0; m < 4; m++) begin
         b    = {s6_ctx_ff.base[m][BW-1], s6_ctx_ff.base[m]};
         ypos = (yx[CW] ^ signs_ff[3*m+2]);
         ypos = !ypos;
         room = ypos ? (hi - b) : (b - lo);
         s7_num_in[m] = room[BW] ? '0 : room[NW-1:0];
         s7_den_in[m] = yx[CW] ? ny[DW-1:0] : yx[DW-1:0];
         s7_ctx_in.zero[m] = yx == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_num_ff <= s7_num_in;
         s7_den_ff <= s7_den_in;
         s7_ctx_ff <= s7_ctx_in;
      end
   end

   // yaw scale division
   logic [SW-1:0] q2 [4];
   ctx2_type      c2_ff [LAT];

   for (genvar m = 0; m < 4; m++) begin : g_div2
      qxm_divider u_div (
         .clock    (clock),
         .enable   (adv),
         .num_in   (s7_num_ff[m]),
         .den_in   (s7_den_ff[m]),
         .quot_out (q2[m])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c2_ff[0] <= s7_ctx_ff;
         for (int i = 1; i < LAT; i++) begin
            c2_ff[i] <= c2_ff[i-1];
         end
      end
   end

   // stage 8: smallest yaw candidate
   logic [SW-1:0] s8_scale_in;
   logic [SW-1:0] s8_scale_ff;
   ctx2_type      s8_ctx_ff;

   always_comb begin
      s8_scale_in = SW'(1) << SF;
      for (int m = 0; m < 4; m++) begin
         if (!c2_ff[LAT-1].zero[m] && (q2[m] < s8_scale_in)) begin
            s8_scale_in = q2[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_scale_ff <= s8_scale_in;
         s8_ctx_ff   <= c2_ff[LAT-1];
      end
   end

   // stage 9: yaw added to motors, applied yaw magnitude
   logic signed [VW-1:0] s9_v_in [4];
   logic [MW-1:0]        s9_mag_in;
   ctx3_type             s9_ctx_in;
   logic signed [VW-1:0] s9_v_ff [4];
   logic [MW-1:0]        s9_mag_ff;
   ctx3_type             s9_ctx_ff;

   always_comb begin
      logic signed [CW:0]    yx;
      logic signed [CW:0]    yc;
      logic signed [CW+SW:0] prod;
      logic [CW-1:0]         ymag;
      yx = {s8_ctx_ff.yaw[CW-1], s8_ctx_ff.yaw};
      ymag = yx[CW] ? CW'(-yx) : yx[CW-1:0];
      for (int m = 0; m < 4; m++) begin
         yc   = signs_ff[3*m+2] ? -yx : yx;
         prod = yc * $signed({1'b0, s8_scale_ff});
         s9_v_in[m] = VW'($signed(s8_ctx_ff.base[m])) + VW'(prod);
      end
      s9_mag_in        = MW'(ymag) * MW'(s8_scale_ff);
      s9_ctx_in.err    = s8_ctx_ff.err;
      s9_ctx_in.yneg   = yx[CW];
      s9_ctx_in.yclamp = s8_ctx_ff.yclamp;
      s9_ctx_in.scale1 = s8_ctx_ff.scale1;
      s9_ctx_in.scale2 = s8_scale_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_v_ff   <= s9_v_in;
         s9_mag_ff <= s9_mag_in;
         s9_ctx_ff <= s9_ctx_in;
      end
   end

   // stage 10: clamp, round, result beat
   qxm_pkg::rsp_type rsp_in;
   qxm_pkg::rsp_type rsp_ff;

   always_comb begin
      logic signed [VW-1:0] lo;
      logic signed [VW-1:0] hi;
      logic signed [VW-1:0] half;
      logic signed [VW-1:0] vc;
      logic signed [VW-1:0] vr;
      logic [PW-1:0]        mot [4];
      logic [MW:0]          magr;
      logic [CW-1:0]        ay;
      logic                 sat;
      lo   = $signed({{(VW - NW){1'b0}}, idle_ff, {WF{1'b0}}});
      hi   = $signed({{(VW - NW){1'b0}}, max_ff, {WF{1'b0}}});
      half = VW'(1) <<< (WF - 1);
      for (int m = 0; m < 4; m++) begin
         vc = s9_v_ff[m];
         if (vc < lo) begin
            vc = lo;
         end
         if (vc > hi) begin
            vc = hi;
         end
         vr     = vc + half;
         mot[m] = vr[WF +: PW];
      end
      magr = {1'b0, s9_mag_ff} + ((MW + 1)'(1) << (SF - 1));
      ay   = s9_ctx_ff.yneg ? -magr[SF +: CW] : magr[SF +: CW];
      sat  = (s9_ctx_ff.scale1 < SW'(qxm_pkg::SAT_THRESH))
          || (s9_ctx_ff.scale2 < SW'(qxm_pkg::SAT_THRESH))
          || s9_ctx_ff.yclamp;
      if (s9_ctx_ff.err) begin
         rsp_in.status      = 1'b1;
         rsp_in.motor_one   = stop_ff;
         rsp_in.motor_two   = stop_ff;
         rsp_in.motor_three = stop_ff;
         rsp_in.motor_four  = stop_ff;
         rsp_in.tilt_scale  = '0;
         rsp_in.twist_scale = '0;
         rsp_in.applied_yaw = '0;
         rsp_in.saturated   = 1'b0;
      end else begin
         rsp_in.status      = 1'b0;
         rsp_in.motor_one   = mot[0];
         rsp_in.motor_two   = mot[1];
         rsp_in.motor_three = mot[2];
         rsp_in.motor_four  = mot[3];
         rsp_in.tilt_scale  = s9_ctx_ff.scale1;
         rsp_in.twist_scale = s9_ctx_ff.scale2;
         rsp_in.applied_yaw = $signed(ay);
         rsp_in.saturated   = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
